### rtl/tile_plane_range_decoder_top_macros.svh
// Assertion macros shared by the tile plane range decoder RTL.
`ifndef TILE_PLANE_RANGE_DECODER_TOP_MACROS_SVH
`define TILE_PLANE_RANGE_DECODER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TPRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define TPRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/tprd_pkg.sv
// ----------------------------------------------------------------------------
// tprd_pkg
// Shared types and constants for the tile plane range decoder.
// ----------------------------------------------------------------------------
package tprd_pkg;

  localparam int TILE_DEF     = 4;
  localparam int IMG_ROWS_DEF = 256;
  localparam int IMG_COLS_DEF = 1024;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RUN   = 2'd1;
  localparam logic [1:0] ERR_UNEXP = 2'd2;

  // Divider widths: 82-bit dividend (|num| << 16), 32-bit divisor (|a|)
  localparam int NUM_W = 66;  // signed numerator width
  localparam int DVD_W = 82;  // |num| << 16
  localparam int DIV_W = 32;  // |a|

  typedef struct packed {
    logic        kind;
    logic        fitted;
    logic [15:0] occupancy;
    logic [7:0]  tile_row;
    logic [9:0]  tile_col;
    logic        skip_tile;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic [10:0] run_length;
    logic [31:0] unfit_value;
  } in_item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [9:0]  pixel_row;
    logic [11:0] pixel_col;
    logic [31:0] range_value;
    logic        from_fit;
    logic        coeffs_taken;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_hdr;    // capture header, update run state
    logic       raw_pix;     // produce raw pixel or unexpected error
    logic       start_pix;   // start computing pixel at pix_idx
    logic [4:0] pix_idx;
    logic       status;      // produce header status result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [15:0] pix_mask;   // pixels to emit for this header
    logic        busy;       // numerator stage or divider working
    logic        res_valid;  // result register full
  } dp_sts_t;

endpackage

### rtl/tile_plane_range_decoder_top.sv
// ----------------------------------------------------------------------------
// tile_plane_range_decoder_top
// Tile plane range decoder: plane-fitted and raw tiles to range pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_item carry tile headers (kind 0) and raw pixel values
//   (kind 1); out_valid/out_ready/out_item carry pixel results and one status
//   result per header, the status result having last set.
//   One input transaction is in work at a time; in_ready is high only while
//   the sequencer is idle and the result register is empty or being read.
//   Raw item: its result is in the output register the cycle after acceptance.
//   Fitted header with occupied pixels and a nonzero divisor: each occupied
//   pixel goes through start, numerator add, 82 divider steps, result write
//   and return to scan; unoccupied pixel indices are skipped, and the status
//   result follows once all NPIX pixel indices have been scanned, NPIX being
//   min(TILE*TILE, 16).
//   With a zero divisor each occupied pixel is written as invalid, undivided.
//   Reset (rst_n low, synchronous) clears run state, coefficients and the raw
//   pixel mask. When the receiver stalls, the result register holds and the
//   sequencer neither starts a pixel nor takes an input until it is free.
// ----------------------------------------------------------------------------
module tile_plane_range_decoder_top #(
  parameter int TILE          = tprd_pkg::TILE_DEF,
  parameter int IMG_TILE_ROWS = tprd_pkg::IMG_ROWS_DEF,
  parameter int IMG_TILE_COLS = tprd_pkg::IMG_COLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tprd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tprd_pkg::out_item_t out_item
);
  tprd_pkg::dp_cmd_t cmd;
  tprd_pkg::dp_sts_t sts;
  logic              res_take;

  assign out_valid = sts.res_valid;
  assign res_take  = out_valid && out_ready;

  tprd_ctrl #(.TILE(TILE)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_item.kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts),
    .res_take (res_take)
  );

  tprd_datapath #(
    .TILE(TILE), .IMG_TILE_ROWS(IMG_TILE_ROWS), .IMG_TILE_COLS(IMG_TILE_COLS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .res      (out_item),
    .res_take (res_take)
  );
endmodule

### rtl/tprd_div.sv
// ----------------------------------------------------------------------------
// tprd_div
// Iterative unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tprd_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [tprd_pkg::DVD_W-1:0] dividend,
  input  logic [tprd_pkg::DIV_W-1:0] divisor,
  output logic                     done,
  output logic                     busy,
  output logic [tprd_pkg::DVD_W-1:0] quotient
);
  localparam int CW = $clog2(tprd_pkg::DVD_W + 1);

  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [tprd_pkg::DVD_W-1:0]    q_r, q_nxt;
  logic [tprd_pkg::DIV_W:0]      rem_r, rem_nxt;
  logic [tprd_pkg::DIV_W-1:0]    dsr_r, dsr_nxt;
  logic [tprd_pkg::DIV_W:0]      trial;
  logic [tprd_pkg::DIV_W+1:0]    diff;

  // One shift-subtract step per cycle
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r[tprd_pkg::DIV_W-1:0], q_r[tprd_pkg::DVD_W-1]};
    diff     = {1'b0, trial} - {2'b00, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(tprd_pkg::DVD_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[tprd_pkg::DIV_W+1]) begin
        rem_nxt = diff[tprd_pkg::DIV_W:0];
        q_nxt   = {q_r[tprd_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[tprd_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign busy     = busy_r;
  assign quotient = q_r;
endmodule

### rtl/tprd_datapath.sv
// ----------------------------------------------------------------------------
// tprd_datapath
// Run state, plane coefficients, numerator build, divider and result register.
// ----------------------------------------------------------------------------
`include "tile_plane_range_decoder_top_macros.svh"
module tprd_datapath #(
  parameter int TILE          = tprd_pkg::TILE_DEF,
  parameter int IMG_TILE_ROWS = tprd_pkg::IMG_ROWS_DEF,
  parameter int IMG_TILE_COLS = tprd_pkg::IMG_COLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tprd_pkg::in_item_t  in_item,
  input  tprd_pkg::dp_cmd_t   cmd,
  output tprd_pkg::dp_sts_t   sts,
  output tprd_pkg::out_item_t res,
  input  logic                res_take
);
  localparam int NPIX = (TILE * TILE > 16) ? 16 : TILE * TILE;
  localparam int TW   = $clog2(TILE + 1);

  logic signed [31:0] coef_r [4];
  logic [10:0] run_total_r, run_pos_r;
  logic [15:0] raw_mask_r;
  logic [7:0]  raw_row_r, hdr_row_r;
  logic [9:0]  raw_col_r, hdr_col_r;
  logic [10:0] pos_r;
  logic        taken_r;
  logic [1:0]  err_r;
  logic [15:0] pix_mask_r;

  tprd_pkg::out_item_t res_r, res_nxt;
  logic                res_v_r, res_v_nxt;

  // Row and column of a pixel index inside the tile, by compares and a subtraction
  function automatic logic [7:0] idx_split(input logic [4:0] idx);
    logic [3:0] r;
    logic [3:0] c;
    r = '0;
    for (int k = 1; k < TILE; k++) begin
      if (32'(idx) >= 32'(k * TILE)) r = 4'(k);
    end
    c = 4'(32'(idx) - 32'(r) * TILE);
    return {r, c};
  endfunction

  // Header decode
  logic        in_img;
  logic [15:0] occ;
  logic        in_run;
  always_comb begin
    in_img = (32'(in_item.tile_row) < 32'(IMG_TILE_ROWS)) &&
             (32'(in_item.tile_col) < 32'(IMG_TILE_COLS));
    occ = in_img ? (in_item.occupancy & 16'((17'd1 << NPIX) - 17'd1)) : 16'd0;
    in_run = (in_item.tile_col != 10'd0) && (run_pos_r < run_total_r);
  end

  // Raw pixel index: lowest set bit of the remaining mask
  logic [3:0] raw_idx;
  always_comb begin
    raw_idx = 4'd15;
    for (int k = 15; k >= 0; k--) begin
      if (raw_mask_r[k]) raw_idx = 4'(k);
    end
  end

  // Pixel coordinates inside tile
  logic [TW-1:0] pj, pi;
  logic [7:0]    pix_rc, raw_rc;
  always_comb begin
    pix_rc = idx_split(cmd.pix_idx);
    raw_rc = idx_split({1'b0, raw_idx});
    pj     = TW'(pix_rc[7:4]);
    pi     = TW'(pix_rc[3:0]);
  end

  // Numerator stage: products registered before the sum
  logic signed [tprd_pkg::NUM_W-1:0] pb_r, pc_r;
  logic        num_v_r;
  logic signed [tprd_pkg::NUM_W-1:0] num;
  logic [tprd_pkg::NUM_W-1:0]        num_abs;
  logic [31:0]                       a_abs;
  logic [9:0]  pr_r;
  logic [11:0] pcol_r;
  logic [15:0] kcol;
  always_comb begin
    kcol    = 16'(pos_r * TILE) + 16'(pi);
    num     = 66'(coef_r[3]) + pb_r + pc_r;
    num_abs = num[tprd_pkg::NUM_W-1] ? 66'(-num) : num;
    a_abs   = coef_r[0][31] ? 32'(-coef_r[0]) : coef_r[0];
  end

  logic                          div_done, div_busy;
  logic [tprd_pkg::DVD_W-1:0]    quo;
  logic [tprd_pkg::DVD_W-1:0]    dvd;
  assign dvd = {num_abs[tprd_pkg::DVD_W-17:0], 16'd0};

  tprd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (num_v_r && (coef_r[0] != 32'sd0)),
    .dividend (dvd),
    .divisor  (a_abs),
    .done     (div_done),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Result register next value
  always_comb begin
    res_v_nxt = res_v_r && !res_take;
    res_nxt   = res_r;
    if (cmd.status) begin
      res_v_nxt              = 1'b1;
      res_nxt                = '0;
      res_nxt.coeffs_taken   = taken_r;
      res_nxt.error_code     = err_r;
      res_nxt.last           = 1'b1;
    end else if (div_done) begin
      res_v_nxt              = 1'b1;
      res_nxt                = '0;
      res_nxt.pixel_valid    = 1'b1;
      res_nxt.pixel_row      = pr_r;
      res_nxt.pixel_col      = pcol_r;
      res_nxt.from_fit       = 1'b1;
      res_nxt.range_value    = (|quo[tprd_pkg::DVD_W-1:32]) ? 32'hFFFF_FFFF : quo[31:0];
    end else if (num_v_r && coef_r[0] == 32'sd0) begin
      // Divisor zero: pixel invalid, no division
      res_v_nxt              = 1'b1;
      res_nxt                = '0;
      res_nxt.pixel_row      = pr_r;
      res_nxt.pixel_col      = pcol_r;
      res_nxt.from_fit       = 1'b1;
    end else if (cmd.raw_pix) begin
      res_v_nxt              = 1'b1;
      res_nxt                = '0;
      res_nxt.last           = 1'b1;
      if (raw_mask_r == 16'd0) begin
        res_nxt.error_code   = tprd_pkg::ERR_UNEXP;
      end else begin
        res_nxt.pixel_valid  = 1'b1;
        res_nxt.pixel_row    = 10'(raw_row_r * TILE + 32'(raw_rc[7:4]));
        res_nxt.pixel_col    = 12'(raw_col_r * TILE + 32'(raw_rc[3:0]));
        res_nxt.range_value  = in_item.unfit_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) coef_r[k] <= '0;
      run_total_r <= '0;
      run_pos_r   <= '0;
      raw_mask_r  <= '0;
      raw_row_r   <= '0;
      raw_col_r   <= '0;
      res_v_r     <= 1'b0;
      res_r       <= '0;
      num_v_r     <= 1'b0;
      pix_mask_r  <= '0;
    end else begin
      res_v_r <= res_v_nxt;
      res_r   <= res_nxt;
      num_v_r <= cmd.start_pix;
      // Header: run bookkeeping and coefficient latch
      if (cmd.load_hdr) begin
        hdr_row_r  <= in_item.tile_row;
        hdr_col_r  <= in_item.tile_col;
        raw_mask_r <= in_item.fitted ? 16'd0 : occ;
        pix_mask_r <= (in_item.fitted && !in_item.skip_tile) ? occ : 16'd0;
        taken_r    <= in_item.fitted && !in_run;
        err_r      <= (!in_item.fitted && in_run) ? tprd_pkg::ERR_RUN : tprd_pkg::ERR_OK;
        if (!in_item.fitted) begin
          raw_row_r <= in_item.tile_row;
          raw_col_r <= in_item.tile_col;
          if (in_item.tile_col == 10'd0) begin
            for (int k = 0; k < 4; k++) coef_r[k] <= '0;
            run_total_r <= '0;
            run_pos_r   <= '0;
          end
        end else if (in_run) begin
          pos_r     <= run_pos_r;
          run_pos_r <= run_pos_r + 11'd1;
        end else begin
          coef_r[0]   <= in_item.coef_a;
          coef_r[1]   <= in_item.coef_b;
          coef_r[2]   <= in_item.coef_c;
          coef_r[3]   <= in_item.coef_d;
          run_total_r <= in_item.run_length;
          pos_r       <= '0;
          run_pos_r   <= 11'd1;
        end
      end else if (cmd.raw_pix && raw_mask_r != 16'd0) begin
        // Raw item consumes the lowest pending pixel
        raw_mask_r[raw_idx] <= 1'b0;
      end
      // Pixel start: register products
      if (cmd.start_pix) begin
        pb_r    <= 66'(coef_r[1]) * $signed({1'b0, 8'(pj)});
        pc_r    <= 66'(coef_r[2]) * $signed({1'b0, kcol});
        pr_r    <= 10'(hdr_row_r * TILE + 32'(pj));
        pcol_r  <= 12'(hdr_col_r * TILE + 32'(pi));
      end
    end
  end

  assign sts.pix_mask  = pix_mask_r;
  assign sts.busy      = div_busy || num_v_r || div_done;
  assign sts.res_valid = res_v_r;
  assign res           = res_r;

  `TPRD_ASSERT_IMP(a_div_no_cmd, clk, rst_n, div_busy, !cmd.start_pix,
                   "pixel started while divider busy")
  `TPRD_ASSERT_IMP(a_res_free, clk, rst_n, div_done, !res_v_r || res_take,
                   "divider result would overwrite pending result")
  `TPRD_ASSERT_NXT(a_raw_clear, clk, rst_n, cmd.load_hdr && in_item.fitted,
                   raw_mask_r == 16'd0, "raw mask not cleared by fitted header")
endmodule

### rtl/tprd_ctrl.sv
// ----------------------------------------------------------------------------
// tprd_ctrl
// Sequencer: accepts items, walks occupied pixels, issues status results.
// ----------------------------------------------------------------------------
`include "tile_plane_range_decoder_top_macros.svh"
module tprd_ctrl #(
  parameter int TILE = tprd_pkg::TILE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_ready,
  output tprd_pkg::dp_cmd_t  cmd,
  input  tprd_pkg::dp_sts_t  sts,
  input  logic               res_take
);
  localparam int NPIX = (TILE * TILE > 16) ? 16 : TILE * TILE;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_STAT = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       res_free;

  assign res_free = !sts.res_valid || res_take;
  assign in_ready = (state_r == S_IDLE) && res_free;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.pix_idx = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_kind) begin
            cmd.raw_pix = 1'b1;
          end else begin
            cmd.load_hdr = 1'b1;
            idx_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r >= 5'(NPIX)) begin
          state_nxt = S_STAT;
        end else if (!sts.pix_mask[idx_r[3:0]]) begin
          idx_nxt = idx_r + 5'd1;
        end else if (res_free) begin
          cmd.start_pix = 1'b1;
          idx_nxt   = idx_r + 5'd1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!sts.busy) state_nxt = S_SCAN;
      end
      S_STAT: begin
        if (res_free) begin
          cmd.status = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `TPRD_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1,
                   $countones({cmd.load_hdr, cmd.raw_pix, cmd.start_pix, cmd.status}) <= 1,
                   "more than one command issued")
  `TPRD_ASSERT_NXT(a_hdr_scan, clk, rst_n, cmd.load_hdr, state_r == S_SCAN,
                   "header did not start pixel scan")
endmodule

### bench/tile_plane_range_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for tile_plane_range_decoder_top
// Sends tile headers and raw pixel values through the input handshake and
// checks every result field against a predictor of the decoder: fitted runs,
// raw tiles, error cases, saturation and divisor zero.
// ----------------------------------------------------------------------------
module tile_plane_range_decoder_top_tb;

  localparam int TILE_N = tprd_pkg::TILE_DEF;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  tprd_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  tprd_pkg::out_item_t out_item;

  tile_plane_range_decoder_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // Predictor state
  logic [31:0] pl_a, pl_b, pl_c, pl_d;
  logic [10:0] run_len, run_pos;
  logic [15:0] raw_left;
  logic [7:0]  raw_trow;
  logic [9:0]  raw_tcol;

  tprd_pkg::out_item_t expected_px[$];
  int  n_fail;
  int  n_items;
  int  n_results;
  bit  idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("status: fail");
    $finish;
  end

  function automatic tprd_pkg::out_item_t mk(logic v, logic [9:0] r, logic [11:0] c,
                                             logic [31:0] val, logic f, logic t,
                                             logic [1:0] e, logic l);
    tprd_pkg::out_item_t o;
    o.pixel_valid = v; o.pixel_row = r; o.pixel_col = c; o.range_value = val;
    o.from_fit = f; o.coeffs_taken = t; o.error_code = e; o.last = l;
    return o;
  endfunction

  // |(d + b*j + c*k) / a| in Q16.16 with saturation
  function automatic logic [31:0] plane_range(int unsigned j, int unsigned k);
    logic signed [65:0] num;
    logic [65:0] an;
    logic [31:0] ad;
    logic [81:0] q;
    num = $signed(pl_d) + $signed(pl_b) * $signed({1'b0, 32'(j)})
          + $signed(pl_c) * $signed({1'b0, 32'(k)});
    an = num[65] ? 66'(-num) : 66'(num);
    ad = pl_a[31] ? 32'(-pl_a) : pl_a;
    q = {an, 16'd0} / ad;
    return (q > 82'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
  endfunction

  task automatic predict_item(input tprd_pkg::in_item_t it);
    logic [15:0] occ;
    logic [10:0] pos;
    logic taken;
    int idx;
    int bitn;
    occ = it.occupancy;
    if (it.kind) begin
      if (raw_left == 0) begin
        expected_px.push_back(mk(0, 0, 0, 0, 0, 0, tprd_pkg::ERR_UNEXP, 1));
      end else begin
        idx = 0;
        while (idx < 15 && !raw_left[idx]) idx++;
        raw_left[idx] = 1'b0;
        expected_px.push_back(mk(1, 10'(raw_trow * TILE_N + idx / TILE_N),
                                 12'(raw_tcol * TILE_N + idx % TILE_N),
                                 it.unfit_value, 0, 0, tprd_pkg::ERR_OK, 1));
      end
      return;
    end
    if (TILE_N * TILE_N < 16) occ = occ & ((16'd1 << (TILE_N * TILE_N)) - 1);
    if (it.tile_row >= tprd_pkg::IMG_ROWS_DEF || it.tile_col >= tprd_pkg::IMG_COLS_DEF)
      occ = 0;
    raw_left = 0;
    if (it.tile_col == 0) begin
      pl_a = 0; pl_b = 0; pl_c = 0; pl_d = 0; run_len = 0; run_pos = 0;
    end
    if (!it.fitted) begin
      raw_left = occ; raw_trow = it.tile_row; raw_tcol = it.tile_col;
      expected_px.push_back(mk(0, 0, 0, 0, 0, 0,
                               (run_pos < run_len) ? tprd_pkg::ERR_RUN : tprd_pkg::ERR_OK,
                               1));
      return;
    end
    taken = 0;
    if (run_pos < run_len) begin
      pos = run_pos;
    end else begin
      pl_a = it.coef_a; pl_b = it.coef_b; pl_c = it.coef_c; pl_d = it.coef_d;
      run_len = it.run_length; pos = 0; taken = 1;
    end
    run_pos = pos + 11'd1;
    if (!it.skip_tile) begin
      bitn = 0;
      for (int j = 0; j < TILE_N; j++) begin
        for (int i = 0; i < TILE_N; i++) begin
          if (bitn < 16 && occ[bitn]) begin
            if (pl_a == 0)
              expected_px.push_back(mk(0, 10'(it.tile_row * TILE_N + j),
                                       12'(it.tile_col * TILE_N + i), 0, 1, 0,
                                       tprd_pkg::ERR_OK, 0));
            else
              expected_px.push_back(mk(1, 10'(it.tile_row * TILE_N + j),
                                       12'(it.tile_col * TILE_N + i),
                                       plane_range(j, pos * TILE_N + i), 1, 0,
                                       tprd_pkg::ERR_OK, 0));
          end
          bitn++;
        end
      end
    end
    expected_px.push_back(mk(0, 0, 0, 0, 0, taken, tprd_pkg::ERR_OK, 1));
  endtask

  // Send one transaction; valid stays high across back-to-back items
  task automatic send_item(input tprd_pkg::in_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    predict_item(it);
    n_items++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver stalls in bursts
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 5);
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    tprd_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_px.size() == 0) begin
        $error("unexpected result %p", out_item);
        n_fail++;
      end else begin
        e = expected_px.pop_front();
        if (out_item.pixel_valid !== e.pixel_valid) begin
          $error("pixel_valid exp %0h got %0h", e.pixel_valid, out_item.pixel_valid);
          n_fail++;
        end
        if (out_item.pixel_row !== e.pixel_row) begin
          $error("pixel_row exp %0h got %0h", e.pixel_row, out_item.pixel_row);
          n_fail++;
        end
        if (out_item.pixel_col !== e.pixel_col) begin
          $error("pixel_col exp %0h got %0h", e.pixel_col, out_item.pixel_col);
          n_fail++;
        end
        if (out_item.range_value !== e.range_value) begin
          $error("range_value exp %0h got %0h", e.range_value, out_item.range_value);
          n_fail++;
        end
        if (out_item.from_fit !== e.from_fit) begin
          $error("from_fit exp %0h got %0h", e.from_fit, out_item.from_fit);
          n_fail++;
        end
        if (out_item.coeffs_taken !== e.coeffs_taken) begin
          $error("coeffs_taken exp %0h got %0h", e.coeffs_taken, out_item.coeffs_taken);
          n_fail++;
        end
        if (out_item.error_code !== e.error_code) begin
          $error("error_code exp %0h got %0h", e.error_code, out_item.error_code);
          n_fail++;
        end
        if (out_item.last !== e.last) begin
          $error("last exp %0h got %0h", e.last, out_item.last);
          n_fail++;
        end
      end
    end
  end

  function automatic tprd_pkg::in_item_t hdr(logic fit, logic [15:0] occ, logic [7:0] r,
                                             logic [9:0] c, logic sk, logic [31:0] a,
                                             logic [31:0] b, logic [31:0] cc,
                                             logic [31:0] d, logic [10:0] rl);
    tprd_pkg::in_item_t it;
    it = '0;
    it.fitted = fit; it.occupancy = occ; it.tile_row = r; it.tile_col = c;
    it.skip_tile = sk; it.coef_a = a; it.coef_b = b; it.coef_c = cc; it.coef_d = d;
    it.run_length = rl;
    it.unfit_value = $urandom();
    return it;
  endfunction

  function automatic tprd_pkg::in_item_t raw(logic [31:0] v);
    tprd_pkg::in_item_t it;
    logic [223:0] rnd;
    rnd = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom()};
    it = rnd[207:0];
    it.kind = 1'b1;
    it.unfit_value = v;
    return it;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      1: return 32'h80000000;
      2: return 32'h7FFFFFFF;
      default: return $urandom();
    endcase
  endfunction

  // Fitted runs, skip, divisor zero, saturation, extreme coefficients
  task automatic test_fitted_runs();
    send_item(hdr(1, 16'hFFFF, 0, 0, 0, 32'h00010000, 32'h00020000, 32'hFFFF0000,
                  32'h00100000, 3));
    send_item(hdr(1, 16'hA5A5, 0, 1, 1, 0, 0, 0, 0, 0));
    send_item(hdr(1, 16'h8001, 0, 2, 0, 0, 0, 0, 0, 0));
    send_item(hdr(1, 16'h0F0F, 255, 0, 0, 32'h00000001, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 11'd1024));
    send_item(hdr(1, 16'hFFFF, 255, 1023, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 0));
    send_item(hdr(1, 16'h00FF, 3, 0, 0, 0, 32'h1, 32'h1, 32'h1, 2));
    send_item(hdr(1, 16'h0000, 3, 1, 0, 0, 0, 0, 0, 0));
  endtask

  // Raw tiles, raw tile inside run, header dropping raw pixels, stray raw value
  task automatic test_raw_tiles();
    send_item(raw(32'hFFFFFFFF));
    send_item(hdr(0, 16'h8421, 7, 0, 0, 0, 0, 0, 0, 0));
    send_item(raw(32'h0));
    send_item(raw(32'hFFFFFFFF));
    send_item(hdr(1, 16'h0001, 7, 1, 0, 32'h00010000, 0, 0, 32'h5, 4));
    send_item(hdr(0, 16'hFFFF, 7, 2, 0, 0, 0, 0, 0, 0));
    send_item(raw(32'h12345678));
    send_item(hdr(0, 16'h8000, 255, 1023, 0, 0, 0, 0, 0, 0));
    send_item(raw(32'hA5A5A5A5));
    send_item(raw(32'h1));
  endtask

  // Random tile rows: mostly well-formed runs with raw tiles, some noise
  task automatic test_random_rows(input int n_target);
    tprd_pkg::in_item_t it;
    logic [7:0] trow;
    logic [9:0] tcol;
    int nraw;
    while (n_items < n_target) begin
      trow = $urandom_range(0, 9) == 0 ? 8'hFF : 8'($urandom);
      tcol = 0;
      repeat ($urandom_range(2, 8)) begin
        // sparse masks keep divider time bounded
        it = hdr($urandom_range(0, 3) != 0,
                 $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'(1 << $urandom_range(0, 15))
                   | 16'(1 << $urandom_range(0, 15)),
                 trow, ($urandom_range(0, 15) == 0) ? 10'($urandom) : tcol,
                 $urandom_range(0, 5) == 0,
                 $urandom_range(0, 9) == 0 ? 32'd0 : rand_coef(), rand_coef(), rand_coef(),
                 rand_coef(), $urandom_range(0, 7) == 0 ? 11'($urandom_range(0, 1024))
                                                        : 11'($urandom_range(0, 4)));
        send_item(it);
        if (!it.fitted) begin
          nraw = $countones(it.occupancy) + int'($urandom_range(0, 2)) - 1;
          if (nraw < 0) nraw = 0;
          repeat (nraw) send_item(raw($urandom()));
        end
        tcol = tcol + 1;
      end
    end
  endtask

  initial begin
    int wait_cyc;
    rst_n = 1'b0; in_valid = 1'b0; in_item = '0;
    pl_a = 0; pl_b = 0; pl_c = 0; pl_d = 0; run_len = 0; run_pos = 0;
    raw_left = 0; raw_trow = 0; raw_tcol = 0;
    n_fail = 0; n_items = 0; n_results = 0; idle_on = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fitted_runs();
    test_raw_tiles();
    test_random_rows(300);
    idle_on = 1'b0;
    test_random_rows(360);
    in_valid <= 1'b0;
    wait_cyc = 0;
    while (expected_px.size() != 0 && wait_cyc < 200000) begin
      @(posedge clk);
      wait_cyc++;
    end
    if (expected_px.size() != 0) begin
      $error("%0d results never arrived", expected_px.size());
      n_fail++;
    end
    repeat (50) @(posedge clk);
    $display("Sent %0d items (headers, raw pixels, stray values), checked %0d results.",
             n_items, n_results);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
